// ===== design/fdt_pkg.sv =====
// Shared types, step numbers and the control program for the fan duty block.
// No dependencies; imported by every module of the block.
package fdt_pkg;

  localparam int unsigned StepW = 4;
  localparam int unsigned DivW  = 15;  // numerator bits of the band quotient
  localparam int unsigned DivCntW = 4;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RELOAD,
    OP_MUL,
    OP_DIV,
    OP_LIN,
    OP_RUNON,
    OP_MAX,
    OP_MIN,
    OP_KICK,
    OP_FINAL
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_BELOW,
    C_ABOVE,
    C_SPAN0,
    C_DNONPOS,
    C_NOKICK,
    C_DIVMORE
  } cond_e;

  typedef enum logic [2:0] {
    REG_LOW,
    REG_HIGH,
    REG_MIN,
    REG_MAX,
    REG_KICK,
    REG_RUNON,
    REG_NONE6,
    REG_NONE7
  } reg_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
    logic  wait_in;
    logic  wait_out;
  } uword_t;

  typedef struct packed {
    logic [7:0] low_threshold;
    logic [7:0] high_threshold;
    logic [6:0] min_duty;
    logic [6:0] max_duty;
    logic [6:0] kick_duty;
    logic [7:0] run_on_samples;
  } cfg_t;

  typedef struct packed {
    logic below;
    logic above;
    logic span_zero;
    logic drange_nonpos;
    logic no_kick;
    logic div_more;
    logic out_free;
  } status_t;

  localparam step_t StWait   = 4'd0;
  localparam step_t StBelow  = 4'd1;
  localparam step_t StAbove  = 4'd2;
  localparam step_t StReload = 4'd3;
  localparam step_t StRange  = 4'd4;
  localparam step_t StMul    = 4'd5;
  localparam step_t StDiv    = 4'd6;
  localparam step_t StLin    = 4'd7;
  localparam step_t StRunOn  = 4'd8;
  localparam step_t StMax    = 4'd9;
  localparam step_t StMin    = 4'd10;
  localparam step_t StEmit   = 4'd11;
  localparam step_t StKick   = 4'd12;
  localparam step_t StFinal  = 4'd13;

  // Control store: one word per step.
  function automatic uword_t fdt_ucode(step_t step);
    uword_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: StWait, wait_in: 1'b0, wait_out: 1'b0};
    unique case (step)
      StWait:   w = '{OP_LATCH,  C_NEVER,   StWait,  1'b1, 1'b0};
      StBelow:  w = '{OP_NONE,   C_BELOW,   StRunOn, 1'b0, 1'b0};
      StAbove:  w = '{OP_NONE,   C_ABOVE,   StMax,   1'b0, 1'b0};
      StReload: w = '{OP_RELOAD, C_SPAN0,   StMax,   1'b0, 1'b0};
      StRange:  w = '{OP_NONE,   C_DNONPOS, StMin,   1'b0, 1'b0};
      StMul:    w = '{OP_MUL,    C_NEVER,   StWait,  1'b0, 1'b0};
      StDiv:    w = '{OP_DIV,    C_DIVMORE, StDiv,   1'b0, 1'b0};
      StLin:    w = '{OP_LIN,    C_ALWAYS,  StEmit,  1'b0, 1'b0};
      StRunOn:  w = '{OP_RUNON,  C_ALWAYS,  StEmit,  1'b0, 1'b0};
      StMax:    w = '{OP_MAX,    C_ALWAYS,  StEmit,  1'b0, 1'b0};
      StMin:    w = '{OP_MIN,    C_NEVER,   StWait,  1'b0, 1'b0};
      StEmit:   w = '{OP_NONE,   C_NOKICK,  StFinal, 1'b0, 1'b0};
      StKick:   w = '{OP_KICK,   C_NEVER,   StWait,  1'b0, 1'b1};
      StFinal:  w = '{OP_FINAL,  C_ALWAYS,  StWait,  1'b0, 1'b1};
      default:  w = '{OP_NONE,   C_ALWAYS,  StWait,  1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== design/fdt_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fdt_pkg.
module fdt_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  fdt_pkg::status_t status_i,
  output logic            in_ready_o,
  output fdt_pkg::op_e    op_o
);
  import fdt_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   stall;
  logic   taken;

  always_comb begin
    word  = fdt_ucode(step_q);
    stall = (word.wait_in && !in_valid_i) || (word.wait_out && !status_i.out_free);
    unique case (word.cond)
      C_NEVER:   taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_BELOW:   taken = status_i.below;
      C_ABOVE:   taken = status_i.above;
      C_SPAN0:   taken = status_i.span_zero;
      C_DNONPOS: taken = status_i.drange_nonpos;
      C_NOKICK:  taken = status_i.no_kick;
      C_DIVMORE: taken = status_i.div_more;
      default:   taken = 1'b0;
    endcase
    // hold the step and suppress the operation while waiting on a handshake
    if (stall) begin
      step_d = step_q;
      op_o   = OP_NONE;
    end else begin
      step_d = taken ? word.target : step_q + step_t'(1);
      op_o   = word.op;
    end
    in_ready_o = word.wait_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== design/fdt_dpath.sv =====
// Datapath: sample and state registers, multiplier, serial divider, result register.
// Depends on fdt_pkg; driven one operation per cycle by fdt_seq.
module fdt_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fdt_pkg::op_e     op_i,
  input  fdt_pkg::cfg_t    cfg_i,
  input  logic [7:0]       temperature_i,
  input  logic             out_ready_i,
  output fdt_pkg::status_t status_o,
  output logic             out_valid_o,
  output logic [6:0]       duty_o,
  output logic             is_kick_o,
  output logic             last_o
);
  import fdt_pkg::*;

  logic [7:0]         temp_q;
  logic [7:0]         run_cnt_q;
  logic [6:0]         prev_q;
  logic [6:0]         duty_q;
  logic [DivW-1:0]    num_q;
  logic [7:0]         rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  logic [6:0]         out_duty_q;
  logic               out_kick_q;
  logic               out_last_q;

  logic [8:0]      span9;
  logic [8:0]      dt9;
  logic [6:0]      drange;
  logic [DivW-1:0] prod;
  logic [8:0]      trial;
  logic [8:0]      diff;
  logic            ge;

  always_comb begin
    span9  = {cfg_i.high_threshold[7], cfg_i.high_threshold}
           - {cfg_i.low_threshold[7], cfg_i.low_threshold};
    dt9    = {temp_q[7], temp_q} - {cfg_i.low_threshold[7], cfg_i.low_threshold};
    drange = cfg_i.max_duty - cfg_i.min_duty;
    prod   = {8'b0, drange} * {7'b0, dt9[7:0]};
    // one restoring divide step; remainder stays below the span
    trial  = {rem_q, num_q[DivW-1]};
    diff   = trial - {1'b0, span9[7:0]};
    ge     = (trial >= {1'b0, span9[7:0]});

    status_o.below         = $signed(temp_q) < $signed(cfg_i.low_threshold);
    status_o.above         = $signed(temp_q) > $signed(cfg_i.high_threshold);
    status_o.span_zero     = (cfg_i.high_threshold == cfg_i.low_threshold);
    status_o.drange_nonpos = (cfg_i.max_duty <= cfg_i.min_duty);
    status_o.no_kick       = (duty_q == 7'd0) || (prev_q != 7'd0);
    status_o.div_more      = (cnt_q != DivCntW'(1));
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q   <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_KICK || op_i == OP_FINAL) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (op_i)
        OP_RELOAD: run_cnt_q <= cfg_i.run_on_samples;
        OP_RUNON: begin
          if (run_cnt_q != 8'd0) begin
            run_cnt_q <= run_cnt_q - 8'd1;
          end
        end
        OP_MUL:   cnt_q <= DivCntW'(DivW);
        OP_DIV:   cnt_q <= cnt_q - DivCntW'(1);
        OP_FINAL: prev_q <= duty_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LATCH: temp_q <= temperature_i;
      OP_MUL: begin
        num_q <= prod;
        rem_q <= '0;
      end
      OP_DIV: begin
        num_q <= {num_q[DivW-2:0], ge};
        rem_q <= ge ? diff[7:0] : trial[7:0];
      end
      OP_LIN:   duty_q <= cfg_i.min_duty + num_q[6:0];
      OP_RUNON: duty_q <= (run_cnt_q != 8'd0) ? cfg_i.min_duty : 7'd0;
      OP_MAX:   duty_q <= cfg_i.max_duty;
      OP_MIN:   duty_q <= cfg_i.min_duty;
      OP_KICK: begin
        out_duty_q <= cfg_i.kick_duty;
        out_kick_q <= 1'b1;
        out_last_q <= 1'b0;
      end
      OP_FINAL: begin
        out_duty_q <= duty_q;
        out_kick_q <= 1'b0;
        out_last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = out_duty_q;
  assign is_kick_o   = out_kick_q;
  assign last_o      = out_last_q;

endmodule

// ===== design/fan_duty_from_temperature.sv =====
// Fan duty controller: one temperature sample in, one or two duty results out
// (a start-up kick result ahead of the final one when the fan leaves stop). One
// sample is handled at a time. From acceptance until the final result enters the
// output register, the program takes one of these paths:
//   below the low threshold: run-on duty
//   above the high threshold: maximum duty
//   equal thresholds: maximum duty
//   band with max at or under min: minimum duty
//   linear band: multiply, the 15-step restoring divider run by the microcode loop
// A kick result ahead of the final one adds a step, and a result held by the
// consumer stalls the program. The next sample can be accepted in the cycle
// after the final result is loaded. A pending result in the output register
// does not block the next sample from being accepted once the program returns to
// its wait step. Configuration through the APB port while idle. Depends on fdt_pkg,
// fdt_seq, fdt_dpath.
module fan_duty_from_temperature (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] temperature
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] duty, [7] zero
  output logic        m_axis_tuser,   // [0] is_kick
  output logic        m_axis_tlast
);
  import fdt_pkg::*;

  cfg_t    cfg_q;
  status_t status;
  op_e     op;
  logic    cfg_wr;
  reg_e    reg_idx;
  logic [6:0] duty;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= 8'd55;
      cfg_q.high_threshold <= 8'd75;
      cfg_q.min_duty       <= 7'd50;
      cfg_q.max_duty       <= 7'd100;
      cfg_q.kick_duty      <= 7'd70;
      cfg_q.run_on_samples <= 8'd15;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LOW:   cfg_q.low_threshold  <= pwdata[7:0];
        REG_HIGH:  cfg_q.high_threshold <= pwdata[7:0];
        REG_MIN:   cfg_q.min_duty       <= pwdata[6:0];
        REG_MAX:   cfg_q.max_duty       <= pwdata[6:0];
        REG_KICK:  cfg_q.kick_duty      <= pwdata[6:0];
        REG_RUNON: cfg_q.run_on_samples <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOW:   prdata = {24'b0, cfg_q.low_threshold};
      REG_HIGH:  prdata = {24'b0, cfg_q.high_threshold};
      REG_MIN:   prdata = {25'b0, cfg_q.min_duty};
      REG_MAX:   prdata = {25'b0, cfg_q.max_duty};
      REG_KICK:  prdata = {25'b0, cfg_q.kick_duty};
      REG_RUNON: prdata = {24'b0, cfg_q.run_on_samples};
      default:   prdata = '0;
    endcase
  end

  fdt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .op_o       (op)
  );

  fdt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .cfg_i         (cfg_q),
    .temperature_i (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .duty_o        (duty),
    .is_kick_o     (m_axis_tuser),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, duty};

  // one sample at a time: the wait step is left right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // a kick result is never the final one and carries the kick duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && (duty == cfg_q.kick_duty))
    else $error("malformed kick result");

  // an input is only taken when the program sits in its wait step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> op == OP_LATCH)
    else $error("input accepted outside the wait step");

endmodule

// ===== tb/fdt_duty_checker.sv =====
`timescale 1ns / 100ps
// Checker for the fan duty block: watches the APB and both stream channels,
// keeps its own copy of the settings and controller state, and compares results.
// Depends on fdt_pkg for the register codes.
module fdt_duty_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] temperature
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [6:0] duty, [7] zero
  input  logic        m_axis_tuser,   // [0] is_kick
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);
  import fdt_pkg::*;

  typedef struct packed {
    logic [6:0] duty;
    logic       is_kick;
    logic       last;
  } duty_rec_t;

  duty_rec_t expected_duties[$];
  int mismatches = 0;

  // Settings mirror
  logic signed [7:0] low_thr;
  logic signed [7:0] high_thr;
  logic [6:0]        min_d;
  logic [6:0]        max_d;
  logic [6:0]        kick_d;
  logic [7:0]        run_on_len;

  // Controller state
  logic [7:0] run_on_left;
  logic [6:0] prev_duty;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic update_setting(input reg_e idx, input logic [31:0] wdata);
    case (idx)
      REG_LOW:   low_thr = wdata[7:0];
      REG_HIGH:  high_thr = wdata[7:0];
      REG_MIN:   min_d = wdata[6:0];
      REG_MAX:   max_d = wdata[6:0];
      REG_KICK:  kick_d = wdata[6:0];
      REG_RUNON: run_on_len = wdata[7:0];
      default: ;  // unmapped index: drop the write
    endcase
  endtask

  task automatic predict_duty(input logic [7:0] raw);
    int t, lo, hi, mn, mx, num, span, q, p;
    logic [6:0] duty;
    t = $signed(raw);
    lo = low_thr;
    hi = high_thr;
    mn = int'(min_d);
    mx = int'(max_d);
    if (t < lo) begin
      if (run_on_left != 0) begin
        run_on_left = run_on_left - 8'd1;
        duty = min_d;
      end else begin
        duty = '0;
      end
    end else if (t > hi) begin
      duty = max_d;
    end else if (hi == lo) begin
      duty = max_d;
      run_on_left = run_on_len;
    end else begin
      span = hi - lo;
      num = (mx - mn) * (t - lo);
      q = num / span;
      // round toward minus infinity
      if ((num % span) != 0 && num < 0) q -= 1;
      p = mn + q;
      if (p > mx) p = mx;
      if (p < mn) p = mn;
      duty = p[6:0];
      run_on_left = run_on_len;
    end
    if (duty != 0 && prev_duty == 0) expected_duties.push_back('{kick_d, 1'b1, 1'b0});
    expected_duties.push_back('{duty, 1'b0, 1'b1});
    prev_duty = duty;
  endtask

  task automatic check_duty();
    duty_rec_t exp_rec;
    if (expected_duties.size() == 0) begin
      report_mismatch($sformatf("unexpected result duty %0d kick %0b last %0b",
                                m_axis_tdata[6:0], m_axis_tuser, m_axis_tlast));
    end else begin
      exp_rec = expected_duties.pop_front();
      if (m_axis_tdata[6:0] !== exp_rec.duty)
        report_mismatch($sformatf("duty %0d, expected %0d", m_axis_tdata[6:0], exp_rec.duty));
      if (m_axis_tuser !== exp_rec.is_kick)
        report_mismatch($sformatf("is_kick %0b, expected %0b", m_axis_tuser, exp_rec.is_kick));
      if (m_axis_tlast !== exp_rec.last)
        report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, exp_rec.last));
      if (m_axis_tdata[7] !== 1'b0)
        report_mismatch("padding bit of duty item not zero");
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr = 8'sd55;
      high_thr = 8'sd75;
      min_d = 7'd50;
      max_d = 7'd100;
      kick_d = 7'd70;
      run_on_len = 8'd15;
      run_on_left = '0;
      prev_duty = '0;
      expected_duties.delete();
      pending_o <= 0;
    end else begin
      // compare before predicting: a sample taken now cannot answer at this edge
      if (m_axis_tvalid && m_axis_tready) check_duty();
      if (s_axis_tvalid && s_axis_tready) predict_duty(s_axis_tdata);
      if (psel && penable && pwrite && pready) update_setting(reg_e'(paddr[4:2]), pwdata);
      pending_o <= expected_duties.size();
    end
  end

endmodule

// ===== tb/fan_duty_from_temperature_test.sv =====
`timescale 1ns / 100ps
// Top of the fan duty testbench: clock, reset, APB setup, sample stimulus and verdict.
// Depends on fdt_pkg, fan_duty_from_temperature and fdt_duty_checker.
module fan_duty_from_temperature_test;
  import fdt_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int PhaseItems = 125;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int cycles = 0;
  int rx_stall = 0;
  logic out_taken = 1'b0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;

  // Stimulus view of the current settings
  int cur_low = 55;
  int cur_high = 75;
  int cur_runon = 15;

  always #6 clk_i = ~clk_i;

  fan_duty_from_temperature u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  fdt_duty_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: draw a stall after every accepted duty item
  always @(posedge clk_i) out_taken <= m_axis_tvalid && m_axis_tready;

  always @(negedge clk_i) begin
    if (out_taken) rx_stall = rx_quiet ? 0 : $urandom_range(0, 9);
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input reg_e idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold samples back until every predicted duty item has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int lo, input int hi, input int mn, input int mx,
                               input int kk, input int ro);
    wait_drained();
    write_reg(REG_LOW, lo & 8'hFF);
    write_reg(REG_HIGH, hi & 8'hFF);
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
    write_reg(REG_KICK, kk);
    write_reg(REG_RUNON, ro);
    cur_low = lo;
    cur_high = hi;
    cur_runon = ro;
  endtask

  task automatic send_temp(input int t);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= t[7:0];
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic random_setting();
    int lo, hi, mn, mx, kk, ro;
    lo = $urandom_range(0, 255) - 128;
    case ($urandom_range(0, 7))
      0: hi = lo;
      1: hi = $urandom_range(0, 255) - 128;
      2: begin
        lo = -128;
        hi = 127;
      end
      default: begin
        hi = lo + $urandom_range(1, 30);
        if (hi > 127) hi = 127;
      end
    endcase
    case ($urandom_range(0, 5))
      0: mn = 0;
      1: mn = $urandom_range(0, 127);
      default: mn = $urandom_range(0, 60);
    endcase
    case ($urandom_range(0, 5))
      0: mx = $urandom_range(0, 127);
      1: mx = 127;
      default: mx = (mn > 100) ? 127 : $urandom_range(mn, 100);
    endcase
    kk = $urandom_range(0, 127);
    case ($urandom_range(0, 7))
      0: ro = 0;
      1: ro = 255;
      default: ro = $urandom_range(1, 20);
    endcase
    apply_setting(lo, hi, mn, mx, kk, ro);
  endtask

  function automatic int below_temp();
    if (cur_low > -128) return $urandom_range(0, cur_low + 127) - 128;
    return $urandom_range(0, 255) - 128;
  endfunction

  initial begin
    int below_left;
    int t;
    int n;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: stop, band edges, above, run-on after leaving the band
    send_temp(54);
    send_temp(55);
    send_temp(65);
    send_temp(75);
    send_temp(76);
    send_temp(127);
    send_temp(-128);
    send_temp(54);

    // Equal thresholds, short run-on that runs out, then restart with a kick
    apply_setting(20, 20, 30, 90, 127, 2);
    send_temp(20);
    send_temp(19);
    send_temp(19);
    send_temp(19);
    send_temp(21);

    // Zero minimum: run-on counts down at duty 0
    apply_setting(-10, 10, 0, 60, 0, 3);
    send_temp(0);
    send_temp(-20);
    send_temp(-20);
    send_temp(-20);
    send_temp(-20);

    // Low above high: no band at all
    apply_setting(30, 10, 0, 100, 5, 1);
    send_temp(20);
    send_temp(30);
    send_temp(10);

    // Minimum above maximum: minimum wins; unmapped writes are dropped
    apply_setting(0, 100, 90, 40, 127, 1);
    write_reg(REG_NONE6, $urandom());
    write_reg(REG_NONE7, $urandom());
    send_temp(50);
    send_temp(0);
    send_temp(100);

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: apply_setting(-128, 127, 0, 127, 127, 255);
        1: apply_setting(127, -128, 127, 0, 0, 0);
        default: random_setting();
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      below_left = 0;
      for (n = 0; n < PhaseItems; n++) begin
        if (below_left > 0) begin
          t = below_temp();
          below_left--;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              if (cur_low <= cur_high) t = cur_low + $urandom_range(0, cur_high - cur_low);
              else t = $urandom_range(0, 255) - 128;
            end
            4, 5: begin
              // a run of cold samples, at times long enough to use up the run-on
              below_left = $urandom_range(1, cur_runon + 2);
              if (below_left > 300) below_left = 300;
              t = below_temp();
            end
            6: begin
              if (cur_high < 127) t = cur_high + 1 + $urandom_range(0, 126 - cur_high);
              else t = $urandom_range(0, 255) - 128;
            end
            7: t = $urandom_range(0, 1) ? cur_low : cur_high;
            default: t = $urandom_range(0, 255) - 128;
          endcase
        end
        send_temp(t);
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
